FILE: hw/rtl/gbs_pkg.sv
package gbs_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int COORD_W = 16;
    localparam int AREA_W = 32;
    localparam int INDEX_W = 16;
    localparam int THRESH_W = 17;
    localparam int POS_W = 6;
    localparam int INTER_W = 34;
    localparam int EDGE_ONE = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 17'd32768;

    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_EDGE = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_OUTER,
        ST_INNER,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
    } box_t;

endpackage

FILE: hw/rtl/gbs_iou.sv
// Three-stage overlap test: intersection, union, then cross-multiplied compare.
module gbs_iou (
    input  logic                          aclk,
    input  logic                          in_valid,
    input  gbs_pkg::box_t                 box_a,
    input  gbs_pkg::box_t                 box_b,
    input  logic [gbs_pkg::AREA_W-1:0]    area_a,
    input  logic [gbs_pkg::AREA_W-1:0]    area_b,
    input  logic [gbs_pkg::THRESH_W-1:0]  thresh,
    input  logic                          edge_off,
    output logic                          out_valid,
    output logic                          suppress
);
    logic [gbs_pkg::COORD_W-1:0] x1, y1, x2, y2;
    logic signed [gbs_pkg::COORD_W+2:0] w, h;
    logic [gbs_pkg::COORD_W:0] wc, hc;
    logic [gbs_pkg::COORD_W:0] w_reg, h_reg;
    logic [gbs_pkg::AREA_W:0] asum_reg;
    logic v1_reg, v2_reg;
    logic [gbs_pkg::INTER_W-1:0] inter_reg;
    logic signed [gbs_pkg::INTER_W+1:0] uni_reg;
    logic [gbs_pkg::INTER_W+16:0] lhs;
    logic [gbs_pkg::INTER_W+gbs_pkg::THRESH_W-1:0] rhs;
    logic [gbs_pkg::THRESH_W-1:0] th_reg;

    always_comb begin
        x1 = (box_a.x1 > box_b.x1) ? box_a.x1 : box_b.x1;
        y1 = (box_a.y1 > box_b.y1) ? box_a.y1 : box_b.y1;
        x2 = (box_a.x2 < box_b.x2) ? box_a.x2 : box_b.x2;
        y2 = (box_a.y2 < box_b.y2) ? box_a.y2 : box_b.y2;
        w = $signed({3'b000, x2}) - $signed({3'b000, x1})
            + (edge_off ? 19'sd16 : 19'sd0);
        h = $signed({3'b000, y2}) - $signed({3'b000, y1})
            + (edge_off ? 19'sd16 : 19'sd0);
        wc = w[gbs_pkg::COORD_W+2] ? '0 : w[gbs_pkg::COORD_W:0];
        hc = h[gbs_pkg::COORD_W+2] ? '0 : h[gbs_pkg::COORD_W:0];
    end

    always_ff @(posedge aclk) begin
        v1_reg    <= in_valid;
        w_reg     <= wc;
        h_reg     <= hc;
        asum_reg  <= {1'b0, area_a} + {1'b0, area_b};
        v2_reg    <= v1_reg;
        inter_reg <= w_reg * h_reg;
        uni_reg   <= $signed({3'b000, asum_reg});
        th_reg    <= thresh;
        out_valid <= v2_reg;
    end

    logic signed [gbs_pkg::INTER_W+1:0] u;
    always_comb begin
        u   = uni_reg - $signed({2'b00, inter_reg});
        lhs = {1'b0, inter_reg, 16'd0};
        rhs = th_reg * u[gbs_pkg::INTER_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (u < 0)
            suppress <= 1'b0;
        else if (u == 0)
            suppress <= (inter_reg != '0);
        else
            suppress <= (lhs >= rhs);
    end
endmodule

FILE: hw/rtl/greedy_box_suppression.sv
// channel | dir | handshake           | payload
// s_      | in  | s_valid/s_ready     | box corners, area, index, final flag
// m_      | out | m_valid/m_ready     | position, index, keep, final flag
// cfg_    | in  | cfg_valid/cfg_ready | register index, data
// Loading accepts boxes while s_ready is high. After the final box, every pair (i,j),
// i<j, with boxes i and j still kept runs through the overlap unit; each pair waits
// for the previous result before the next one is launched. Results then follow,
// with one memory read per result.
// Reset is synchronous, active low; stores and keep flags are set as boxes load.
// m_ready low holds the emit sequence; inputs and cfg wait until the set is emitted.
module greedy_box_suppression #(
    parameter int MAX_BOXES = gbs_pkg::MAX_BOXES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gbs_pkg::INDEX_W-1:0]    s_source_index,
    input  logic [gbs_pkg::COORD_W-1:0]    s_left,
    input  logic [gbs_pkg::COORD_W-1:0]    s_top,
    input  logic [gbs_pkg::COORD_W-1:0]    s_right,
    input  logic [gbs_pkg::COORD_W-1:0]    s_bottom,
    input  logic [gbs_pkg::AREA_W-1:0]     s_box_area,
    input  logic                           s_final_box,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gbs_pkg::POS_W-1:0]      m_position,
    output logic [gbs_pkg::INDEX_W-1:0]    m_original_index,
    output logic                           m_keep,
    output logic                           m_final_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [gbs_pkg::THRESH_W-1:0]   cfg_data
);
    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    gbs_pkg::box_t                 corner_mem [MAX_BOXES];
    logic [gbs_pkg::AREA_W-1:0]    area_mem   [MAX_BOXES];
    logic [gbs_pkg::INDEX_W-1:0]   index_mem  [MAX_BOXES];
    logic [MAX_BOXES-1:0]          keep_reg, keep_next;

    gbs_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [gbs_pkg::THRESH_W-1:0] thresh_reg;
    logic edge_reg;

    // two read ports: a (outer box / emit), b (inner box)
    logic [AW-1:0] ra, rb;
    gbs_pkg::box_t ca_reg, cb_reg;
    logic [gbs_pkg::AREA_W-1:0] aa_reg, ab_reg;
    logic [gbs_pkg::INDEX_W-1:0] idx_reg;
    logic [1:0] phase_reg, phase_next;
    logic test_go, test_done, supp;
    logic m_valid_reg, m_valid_next;
    logic [gbs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic m_keep_reg, m_keep_next, m_fin_reg, m_fin_next;
    logic s_acc, store_ok;

    assign s_ready   = (state_reg == gbs_pkg::ST_LOAD);
    assign cfg_ready = (state_reg == gbs_pkg::ST_LOAD);
    assign s_acc     = s_valid && s_ready;
    assign store_ok  = (count_reg < CW'(MAX_BOXES));

    always_ff @(posedge aclk) begin
        if (s_acc && store_ok) begin
            corner_mem[count_reg[AW-1:0]] <= '{s_left, s_top, s_right, s_bottom};
            area_mem[count_reg[AW-1:0]]   <= s_box_area;
            index_mem[count_reg[AW-1:0]]  <= s_source_index;
        end
        ca_reg  <= corner_mem[ra];
        aa_reg  <= area_mem[ra];
        idx_reg <= index_mem[ra];
        cb_reg  <= corner_mem[rb];
        ab_reg  <= area_mem[rb];
    end

    assign ra = i_reg[AW-1:0];
    assign rb = j_reg[AW-1:0];

    gbs_iou u_iou (
        .aclk      (aclk),
        .in_valid  (test_go),
        .box_a     (ca_reg),
        .box_b     (cb_reg),
        .area_a    (aa_reg),
        .area_b    (ab_reg),
        .thresh    (thresh_reg),
        .edge_off  (edge_reg),
        .out_valid (test_done),
        .suppress  (supp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= gbs_pkg::THRESH_RESET;
            edge_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gbs_pkg::CFG_THRESH: thresh_reg <= cfg_data;
                gbs_pkg::CFG_EDGE:   edge_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gbs_pkg::ST_LOAD;
            count_reg   <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
        keep_reg   <= keep_next;
        pos_reg    <= pos_next;
        m_keep_reg <= m_keep_next;
        m_fin_reg  <= m_fin_next;
    end

    // phase: 0 issue read, 1 launch test, 2 wait for result
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        phase_next   = phase_reg;
        keep_next    = keep_reg;
        m_valid_next = m_valid_reg;
        pos_next     = pos_reg;
        m_keep_next  = m_keep_reg;
        m_fin_next   = m_fin_reg;
        test_go      = 1'b0;
        case (state_reg)
            gbs_pkg::ST_LOAD: begin
                if (s_acc) begin
                    count_next = store_ok ? count_reg + 1'b1 : count_reg;
                    if (store_ok)
                        keep_next[count_reg[AW-1:0]] = 1'b1;
                    if (s_final_box) begin
                        i_next = '0;
                        state_next = gbs_pkg::ST_OUTER;
                    end
                end
            end
            gbs_pkg::ST_OUTER: begin
                if (i_reg + 1'b1 >= count_reg) begin
                    i_next = '0;
                    phase_next = '0;
                    state_next = (count_reg == '0) ? gbs_pkg::ST_LOAD
                                                   : gbs_pkg::ST_EMIT;
                end else if (!keep_reg[i_reg[AW-1:0]]) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = i_reg + 1'b1;
                    phase_next = '0;
                    state_next = gbs_pkg::ST_INNER;
                end
            end
            gbs_pkg::ST_INNER: begin
                case (phase_reg)
                    2'd0: begin
                        if (j_reg >= count_reg) begin
                            i_next = i_reg + 1'b1;
                            state_next = gbs_pkg::ST_OUTER;
                        end else if (!keep_reg[j_reg[AW-1:0]]) begin
                            j_next = j_reg + 1'b1;
                        end else begin
                            phase_next = 2'd1;
                        end
                    end
                    2'd1: begin
                        test_go = 1'b1;
                        phase_next = 2'd2;
                    end
                    default: begin
                        if (test_done) begin
                            if (supp)
                                keep_next[j_reg[AW-1:0]] = 1'b0;
                            j_next = j_reg + 1'b1;
                            phase_next = 2'd0;
                        end
                    end
                endcase
            end
            gbs_pkg::ST_EMIT: begin
                // read of entry i issued this cycle
                state_next = gbs_pkg::ST_EMIT_WAIT;
                m_valid_next = 1'b0;
                pos_next = i_reg[gbs_pkg::POS_W-1:0];
                m_keep_next = keep_reg[i_reg[AW-1:0]];
                m_fin_next = (i_reg + 1'b1 == count_reg);
            end
            gbs_pkg::ST_EMIT_WAIT: begin
                if (!m_valid_reg) begin
                    m_valid_next = 1'b1;
                end else if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_fin_reg) begin
                        count_next = '0;
                        i_next = '0;
                        state_next = gbs_pkg::ST_LOAD;
                    end else begin
                        i_next = i_reg + 1'b1;
                        state_next = gbs_pkg::ST_EMIT;
                    end
                end
            end
            default: state_next = gbs_pkg::ST_LOAD;
        endcase
    end

    logic [gbs_pkg::INDEX_W-1:0] idx_hold_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == gbs_pkg::ST_EMIT_WAIT && !m_valid_reg)
            idx_hold_reg <= idx_reg;
    end

    assign m_valid          = m_valid_reg;
    assign m_position       = pos_reg;
    assign m_original_index = idx_hold_reg;
    assign m_keep           = m_keep_reg;
    assign m_final_result   = m_fin_reg;

    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != gbs_pkg::ST_LOAD) |-> !s_ready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_BOXES))
        else $error("box count overflow");
    a_out_only_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (state_reg == gbs_pkg::ST_EMIT_WAIT))
        else $error("result outside emit");
    a_test_timing: assert property (@(posedge aclk) disable iff (!aresetn)
        test_go |-> ##3 test_done)
        else $error("overlap unit latency");
endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBOX = 64;
    localparam longint CYCLE_LIMIT = 64'd2500000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [gbs_pkg::INDEX_W-1:0] s_source_index = '0;
    logic [gbs_pkg::COORD_W-1:0] s_left = '0, s_top = '0, s_right = '0, s_bottom = '0;
    logic [gbs_pkg::AREA_W-1:0] s_box_area = '0;
    logic s_final_box = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [gbs_pkg::POS_W-1:0] m_position;
    logic [gbs_pkg::INDEX_W-1:0] m_original_index;
    logic m_keep;
    logic m_final_result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = gbs_pkg::CFG_THRESH;
    logic [gbs_pkg::THRESH_W-1:0] cfg_data = '0;

    greedy_box_suppression dut (.*);

    typedef struct packed {
        logic [gbs_pkg::POS_W-1:0] position;
        logic [gbs_pkg::INDEX_W-1:0] original_index;
        logic keep;
        logic final_result;
    } verdict_t;

    // predictor state
    gbs_pkg::box_t corners_q [NBOX];
    logic [gbs_pkg::AREA_W-1:0] areas_q [NBOX];
    logic [gbs_pkg::INDEX_W-1:0] ids_q [NBOX];
    int stored_boxes = 0;
    logic [gbs_pkg::THRESH_W-1:0] thresh_q = gbs_pkg::THRESH_RESET;
    logic edge_q = 1'b0;

    verdict_t verdicts_pending [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    longint cycles = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit box_suppressed(int a, int b);
        longint off, x1, y1, x2, y2, w, h, inter, uni;
        logic [63:0] lhs, rhs;
        off = edge_q ? 16 : 0;
        x1 = corners_q[a].x1 > corners_q[b].x1 ? corners_q[a].x1 : corners_q[b].x1;
        y1 = corners_q[a].y1 > corners_q[b].y1 ? corners_q[a].y1 : corners_q[b].y1;
        x2 = corners_q[a].x2 < corners_q[b].x2 ? corners_q[a].x2 : corners_q[b].x2;
        y2 = corners_q[a].y2 < corners_q[b].y2 ? corners_q[a].y2 : corners_q[b].y2;
        w = x2 - x1 + off;
        h = y2 - y1 + off;
        if (w < 0) w = 0;
        if (h < 0) h = 0;
        inter = w * h;
        uni = longint'(areas_q[a]) + longint'(areas_q[b]) - inter;
        if (uni < 0) return 1'b0;
        if (uni == 0) return inter != 0;
        lhs = 64'(inter) << 16;
        rhs = 64'(thresh_q) * 64'(uni);
        return lhs >= rhs;
    endfunction

    task automatic predict_suppression(gbs_pkg::box_t b, logic [gbs_pkg::AREA_W-1:0] area,
                                       logic [gbs_pkg::INDEX_W-1:0] id, logic fin);
        bit kept [NBOX];
        verdict_t v;
        if (stored_boxes < NBOX) begin
            corners_q[stored_boxes] = b;
            areas_q[stored_boxes] = area;
            ids_q[stored_boxes] = id;
            stored_boxes++;
        end
        if (fin) begin
            for (int i = 0; i < NBOX; i++) kept[i] = 1'b1;
            for (int i = 0; i < stored_boxes; i++) begin
                if (kept[i]) begin
                    for (int j = i + 1; j < stored_boxes; j++)
                        if (kept[j] && box_suppressed(i, j)) kept[j] = 1'b0;
                end
            end
            for (int i = 0; i < stored_boxes; i++) begin
                v.position = gbs_pkg::POS_W'(i);
                v.original_index = ids_q[i];
                v.keep = kept[i];
                v.final_result = (i + 1 == stored_boxes);
                verdicts_pending.push_back(v);
            end
            stored_boxes = 0;
        end
    endtask

    // leaves s_valid high after the request is taken; idle gaps and
    // wait_drained drop it
    task automatic send_box(gbs_pkg::box_t b, logic [gbs_pkg::AREA_W-1:0] area,
                            logic [gbs_pkg::INDEX_W-1:0] id, logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_source_index <= id;
        s_left <= b.x1;
        s_top <= b.y1;
        s_right <= b.x2;
        s_bottom <= b.y2;
        s_box_area <= area;
        s_final_box <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_suppression(b, area, id, fin);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [gbs_pkg::THRESH_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == gbs_pkg::CFG_THRESH) thresh_q = val;
        else edge_q = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (verdicts_pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // boxes clustered so overlaps happen often; area mostly consistent
    task automatic random_box(output gbs_pkg::box_t b,
                              output logic [gbs_pkg::AREA_W-1:0] area);
        int cx, cy, w, h;
        if ($urandom_range(9) == 0) begin
            b = gbs_pkg::box_t'({$urandom, $urandom});
            area = $urandom;
            return;
        end
        cx = $urandom_range(200, 600);
        cy = $urandom_range(200, 600);
        w = $urandom_range(0, 400);
        h = $urandom_range(0, 400);
        b.x1 = gbs_pkg::COORD_W'(cx - w / 2);
        b.y1 = gbs_pkg::COORD_W'(cy - h / 2);
        b.x2 = gbs_pkg::COORD_W'(cx + w / 2);
        b.y2 = gbs_pkg::COORD_W'(cy + h / 2);
        area = (b.x2 - b.x1) * (b.y2 - b.y1);
        if ($urandom_range(4) == 0) area = area + $urandom_range(0, 2000) - 1000;
    endtask

    task automatic send_random_set(int n);
        gbs_pkg::box_t b;
        logic [gbs_pkg::AREA_W-1:0] area;
        for (int i = 0; i < n; i++) begin
            random_box(b, area);
            send_box(b, area, gbs_pkg::INDEX_W'($urandom), i == n - 1);
        end
    endtask

    task automatic test_directed_extremes();
        gbs_pkg::box_t b;
        b = '{x1: 16'h0000, y1: 16'h0000, x2: 16'hffff, y2: 16'hffff};
        send_box(b, 32'hffff_ffff, 16'hffff, 1'b0);
        send_box(b, 32'hffff_ffff, 16'h0000, 1'b0);
        // zero union, nonzero intersection
        b = '{x1: 16'd0, y1: 16'd0, x2: 16'd16, y2: 16'd16};
        send_box(b, 32'd0, 16'd1, 1'b0);
        send_box(b, 32'd256, 16'd2, 1'b0);
        // zero union, zero intersection
        b = '{x1: 16'd100, y1: 16'd100, x2: 16'd100, y2: 16'd100};
        send_box(b, 32'd0, 16'd3, 1'b0);
        send_box(b, 32'd0, 16'd4, 1'b0);
        // negative union
        b = '{x1: 16'd0, y1: 16'd0, x2: 16'd1000, y2: 16'd1000};
        send_box(b, 32'd5, 16'd5, 1'b0);
        send_box(b, 32'd5, 16'd6, 1'b0);
        b = '{x1: 16'hff00, y1: 16'h0, x2: 16'h00ff, y2: 16'hffff};
        send_box(b, 32'h1234_5678, 16'haaaa, 1'b1);
        wait_drained();
        // single-box set
        send_box(b, 32'h0, 16'h5555, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_store();
        gbs_pkg::box_t b;
        // 66 boxes: two ignored, the final one among them
        for (int i = 0; i < NBOX + 2; i++) begin
            b = '{x1: 16'(i * 8), y1: 16'd0, x2: 16'(i * 8 + 160), y2: 16'd160};
            send_box(b, 32'd25600, 16'(i), i == NBOX + 1);
        end
        wait_drained();
    endtask

    task automatic test_config_sweep();
        logic [gbs_pkg::THRESH_W-1:0] th [5] =
            '{17'd0, 17'd65536, 17'd1, 17'h1ffff, 17'd20000};
        for (int k = 0; k < 5; k++) begin
            write_reg(gbs_pkg::CFG_THRESH, th[k]);
            write_reg(gbs_pkg::CFG_EDGE, k[0]);
            send_random_set($urandom_range(2, 12));
            wait_drained();
        end
        write_reg(gbs_pkg::CFG_THRESH, gbs_pkg::THRESH_RESET);
        write_reg(gbs_pkg::CFG_EDGE, 1'b0);
    endtask

    task automatic test_random_sets();
        int idle [4] = '{0, 65, 0, 25};
        int stall [4] = '{0, 0, 65, 25};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle[p];
            recv_stall_pct = stall[p];
            write_reg(gbs_pkg::CFG_THRESH, 17'($urandom_range(16000, 50000)));
            write_reg(gbs_pkg::CFG_EDGE, 1'($urandom));
            for (int s = 0; s < 8; s++) send_random_set($urandom_range(1, 16));
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int s = 0; s < 4; s++) send_random_set($urandom_range(4, 10));
        wait_drained();
    endtask

    // receiver: random stalls, or a long hold-off counted here
    initial begin
        int held;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                for (held = 0; held < 3000; held++) @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_position, m_original_index, m_keep, m_final_result};
            if (verdicts_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = verdicts_pending.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed_extremes();
        test_full_store();
        test_config_sweep();
        test_random_sets();
        test_backpressure();
        wait_drained();
        if (mismatches == 0 && verdicts_pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
